// ===== rtl/rau_pkg.sv =====
`timescale 1ns / 1ps
package rau_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int WIDE = 64;

  typedef enum logic [2:0] {
    K_ADD = 3'd0,
    K_SUB = 3'd1,
    K_MUL = 3'd2,
    K_DIV = 3'd3,
    K_NEG = 3'd4,
    K_RED = 3'd5,
    K_CMP = 3'd6,
    K_NOP = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_ZDEN = 2'd1,
    STAT_OVF  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_FORM,
    ST_TZ,
    ST_GCD,
    ST_DN,
    ST_DD,
    ST_CHK,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// Channel   Dir  tdata                                   tuser
// s_axis    in   a_num, a_den, b_num, b_den (128 bits)   kind (3 bits)
// m_axis    out  res_num, res_den, less, equal (72 bits) status (2 bits)
//
// One transaction at a time: states M0 to M3 on a shared 33x33 multiplier, a
// form step, then a binary GCD (one shift or subtract a cycle) and two
// restoring divisions. Compare, kind seven, zero-numerator and zero-denominator
// cases finish after the form step.
// Reset is synchronous; no output transaction is pending after it.
// A finished result waits in the output register; a stalled m_axis holds the
// next result in the finish state, so no new input is accepted meanwhile.
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_num[31:0], a_den[63:32], b_num[95:64], b_den[126:96], zero
  input  logic [127:0] s_axis_tdata,
  // kind[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // res_num[31:0], res_den[62:32], less[63], equal[64], zero
  output logic [71:0]  m_axis_tdata,
  // status[1:0]
  output logic [1:0]   m_axis_tuser
);

  localparam logic [WIDE-1:0] LIM = WIDE'(1) << (VALUE_WIDTH - 1);

  state_t state, state_next;
  kind_t  kind;

  logic signed [31:0] an, ad, bn;
  logic        [30:0] bd;
  logic signed [32:0] ma, mb;
  logic signed [65:0] mfull;
  logic signed [WIDE-1:0] pr, px, py, pz;
  logic signed [WIDE-1:0] fn, fd, diff;
  logic [WIDE-1:0] un, ud, x, y;
  logic            neg;

  logic [31:0] r_num;
  logic [30:0] r_den;
  logic        r_less, r_equal;
  status_t     r_status;

  logic [31:0] o_num;
  logic [30:0] o_den;
  logic        o_less, o_equal;
  status_t     o_status;

  logic            div_start;
  logic [WIDE-1:0] div_dividend;
  logic [WIDE-1:0] quotient;
  div_stat_t       div_stat;

  logic            out_free;
  logic            accept;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    ma = {an[31], an};
    mb = {2'b00, bd};
    unique case (state)
      ST_M0: begin
        ma = {an[31], an};
        mb = (kind == K_MUL) ? {bn[31], bn} : {2'b00, bd};
      end
      ST_M1: begin
        if (kind == K_MUL) begin
          ma = {ad[31], ad};
          mb = {2'b00, bd};
        end else if (kind == K_DIV) begin
          ma = {ad[31], ad};
          mb = {bn[31], bn};
        end else begin
          ma = {bn[31], bn};
          mb = {ad[31], ad};
        end
      end
      ST_M2: begin
        ma = {ad[31], ad};
        mb = {2'b00, bd};
      end
      default: begin
        ma = {an[31], an};
        mb = {2'b00, bd};
      end
    endcase
  end

  assign mfull = ma * mb;
  assign diff  = px - py;

  always_comb begin
    case (kind) inside
      K_ADD: begin
        fn = px + py;
        fd = pz;
      end
      K_SUB: begin
        fn = diff;
        fd = pz;
      end
      K_MUL, K_DIV: begin
        fn = px;
        fd = py;
      end
      K_NEG: begin
        fn = -WIDE'(an);
        fd = WIDE'(ad);
      end
      default: begin
        fn = WIDE'(an);
        fd = WIDE'(ad);
      end
    endcase
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = un;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_M0;
      ST_M0:   state_next = ST_M1;
      ST_M1:   state_next = ST_M2;
      ST_M2:   state_next = ST_M3;
      ST_M3:   state_next = ST_FORM;
      ST_FORM: begin
        if (kind == K_CMP || kind == K_NOP || fd == '0 || fn == '0) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_TZ;
        end
      end
      ST_TZ: if (x[0] || y[0]) state_next = ST_GCD;
      ST_GCD: begin
        if (x == y) begin
          div_start  = 1'b1;
          state_next = ST_DN;
        end
      end
      ST_DN: begin
        if (div_stat.done) begin
          div_start    = 1'b1;
          div_dividend = ud;
          state_next   = ST_DD;
        end
      end
      ST_DD:  if (div_stat.done) state_next = ST_CHK;
      ST_CHK: state_next = ST_FIN;
      ST_FIN: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  rau_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (x),
    .stat     (div_stat),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    pr <= $signed(mfull[WIDE-1:0]);
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          kind <= kind_t'(s_axis_tuser);
          an   <= s_axis_tdata[31:0];
          ad   <= s_axis_tdata[63:32];
          bn   <= s_axis_tdata[95:64];
          bd   <= s_axis_tdata[126:96];
        end
      end
      ST_M1: px <= pr;
      ST_M2: py <= pr;
      ST_M3: pz <= pr;
      ST_FORM: begin
        r_num    <= '0;
        neg      <= (fn < 0) != (fd < 0);
        un       <= (fn < 0) ? WIDE'(-fn) : WIDE'(fn);
        ud       <= (fd < 0) ? WIDE'(-fd) : WIDE'(fd);
        x        <= (fn < 0) ? WIDE'(-fn) : WIDE'(fn);
        y        <= (fd < 0) ? WIDE'(-fd) : WIDE'(fd);
        if (kind == K_CMP) begin
          r_den    <= '0;
          r_less   <= diff < 0;
          r_equal  <= diff == '0;
          r_status <= STAT_OK;
        end else if (kind != K_NOP && fd == '0) begin
          r_den    <= '0;
          r_less   <= 1'b0;
          r_equal  <= 1'b0;
          r_status <= STAT_ZDEN;
        end else begin
          r_den    <= (kind != K_NOP && fn == '0) ? 31'd1 : 31'd0;
          r_less   <= 1'b0;
          r_equal  <= 1'b0;
          r_status <= STAT_OK;
        end
      end
      ST_TZ: begin
        if (!(x[0] || y[0])) begin
          x  <= x >> 1;
          y  <= y >> 1;
          un <= un >> 1;
          ud <= ud >> 1;
        end
      end
      ST_GCD: begin
        if (x != y) begin
          if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (x > y) begin
            x <= x - y;
          end else begin
            y <= y - x;
          end
        end
      end
      ST_DN: if (div_stat.done) un <= quotient;
      ST_DD: if (div_stat.done) ud <= quotient;
      ST_CHK: begin
        if (ud > LIM - 1 || (neg ? un > LIM : un > LIM - 1)) begin
          r_status <= STAT_OVF;
        end else begin
          r_num <= neg ? 32'(-un) : un[31:0];
          r_den <= ud[30:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      o_num    <= r_num;
      o_den    <= r_den;
      o_less   <= r_less;
      o_equal  <= r_equal;
      o_status <= r_status;
    end
  end

  assign m_axis_tdata = {7'd0, o_equal, o_less, o_den, o_num};
  assign m_axis_tuser = o_status;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DN || state == ST_DD))
    else $error("divider done outside a division step");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == ST_FIN)
    else $error("output transaction not launched from finish");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != STAT_OK) |->
      (m_axis_tdata[62:0] == '0))
    else $error("error result carries a nonzero fraction");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GCD || state == ST_TZ) |-> (x != '0 && y != '0))
    else $error("gcd operand reached zero");

endmodule

// ===== rtl/rau_divider.sv =====
`timescale 1ns / 1ps
module rau_divider import rau_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WIDE-1:0]   dividend,
  input  logic [WIDE-1:0]   divisor,
  output div_stat_t         stat,
  output logic [WIDE-1:0]   quotient
);

  localparam int CW = $clog2(WIDE);

  logic [WIDE-1:0] rem;
  logic [WIDE-1:0] quo;
  logic [WIDE-1:0] dvs;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic            done;
  logic [WIDE:0]   trial;

  assign trial = {rem, quo[WIDE-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(WIDE - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= WIDE'(trial - {1'b0, dvs});
        quo <= {quo[WIDE-2:0], 1'b1};
      end else begin
        rem <= trial[WIDE-1:0];
        quo <= {quo[WIDE-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import rau_pkg::*;

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic        less;
    logic        equal;
    status_t     status;
  } frac_result_t;

  class fraction_scoreboard;
    frac_result_t pending[$];
    int errors;
    int checked;

    function logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      return x;
    endfunction

    function frac_result_t reduce(logic signed [63:0] n, logic signed [63:0] d);
      frac_result_t r;
      logic neg;
      logic [63:0] un, ud, g;
      r = '0;
      if (d == 0) begin
        r.status = STAT_ZDEN;
        return r;
      end
      neg = (n < 0) != (d < 0);
      un = n < 0 ? -n : n;
      ud = d < 0 ? -d : d;
      g = gcd64(un, ud);
      un = un / g;
      ud = ud / g;
      if (un == 0) begin
        neg = 1'b0;
        ud = 1;
      end
      if (ud > 64'h7FFF_FFFF || (neg ? un > 64'h8000_0000 : un > 64'h7FFF_FFFF)) begin
        r.status = STAT_OVF;
        return r;
      end
      r.num = neg ? -un[31:0] : un[31:0];
      r.den = ud[30:0];
      r.status = STAT_OK;
      return r;
    endfunction

    function void note_operands(kind_t k, logic [31:0] an_b, logic [31:0] ad_b,
                                logic [31:0] bn_b, logic [30:0] bd_b);
      logic signed [63:0] an, ad, bn, bd, diff;
      frac_result_t r;
      an = $signed(an_b);
      ad = $signed(ad_b);
      bn = $signed(bn_b);
      bd = {33'd0, bd_b};
      r = '0;
      case (k)
        K_ADD: r = reduce(an * bd + bn * ad, ad * bd);
        K_SUB: r = reduce(an * bd - bn * ad, ad * bd);
        K_MUL: r = reduce(an * bn, ad * bd);
        K_DIV: r = reduce(an * bd, ad * bn);
        K_NEG: r = reduce(-an, ad);
        K_RED: r = reduce(an, ad);
        K_CMP: begin
          diff = an * bd - bn * ad;
          r.less = diff < 0;
          r.equal = diff == 0;
        end
        default: r = '0;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(frac_result_t got);
      frac_result_t want;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.num !== want.num || got.den !== want.den || got.less !== want.less ||
          got.equal !== want.equal || got.status !== want.status) begin
        $display("%0t mismatch:", $time,
                 " expected num %h den %h lt %b eq %b st %0d,",
                 want.num, want.den, want.less, want.equal, want.status,
                 " actual num %h den %h lt %b eq %b st %0d",
                 got.num, got.den, got.less, got.equal, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [127:0] s_axis_tdata;
  logic [2:0] s_axis_tuser;
  logic [71:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  fraction_scoreboard sb;
  longint cycle_count;
  int sent;
  int kind_hits[8];
  bit hold_off;

  rational_arithmetic_unit u_dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3_000_000) begin
      $display("timeout");
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      sb.note_operands(kind_t'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[63:32],
                       s_axis_tdata[95:64], s_axis_tdata[126:96]);
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result({m_axis_tdata[31:0], m_axis_tdata[62:32], m_axis_tdata[63],
                       m_axis_tdata[64], status_t'(m_axis_tuser)});
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int mode;
    m_axis_tready = 0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        m_axis_tready <= 0;
        repeat (3000) @(negedge clk);
        hold_off = 0;
      end
      mode = (cycle_count / 4000) % 3;
      if (mode == 0) m_axis_tready <= 1;
      else if (mode == 1) m_axis_tready <= ($urandom_range(0, 3) != 0);
      else m_axis_tready <= ($urandom_range(0, 3) == 0);
    end
  end

  task automatic send_item(kind_t k, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [30:0] bd);
    s_axis_tvalid <= 1;
    s_axis_tuser <= k;
    s_axis_tdata <= {1'b0, bd, bn, ad, an};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    kind_hits[k]++;
    sent++;
  endtask

  task automatic pause_sender();
    s_axis_tvalid <= 0;
    repeat ($urandom_range(1, 400)) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 20) - 10;
      1: return $urandom_range(1, 1000);
      2: return -$urandom_range(1, 1000);
      3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_den();
    case ($urandom_range(0, 3))
      0: return 31'($urandom_range(1, 12));
      1: return 31'($urandom_range(1, 100000));
      2: return $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0;
      default: return 31'($urandom);
    endcase
  endfunction

  initial begin
    int burst;
    kind_t k;
    logic [31:0] ad;
    sb = new();
    cycle_count = 0;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = K_ADD;
    hold_off = 0;
    repeat (4) @(negedge clk);
    rst = 0;

    send_item(K_ADD, 1, 2, 1, 3);
    send_item(K_SUB, 1, 2, 1, 2);
    send_item(K_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
    send_item(K_MUL, 32'h8000_0000, 1, 1, 1);
    send_item(K_DIV, 3, 4, 0, 5);
    send_item(K_DIV, -6, 4, -9, 2);
    send_item(K_NEG, 32'h8000_0000, 1, 0, 1);
    send_item(K_NEG, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1);
    send_item(K_RED, 6, -4, 0, 1);
    send_item(K_RED, 0, -7, 0, 1);
    send_item(K_RED, 5, 0, 0, 1);
    send_item(K_RED, 32'h8000_0000, -1, 0, 1);
    send_item(K_ADD, 1, 0, 1, 0);
    send_item(K_ADD, 1, 32'h7FFF_FFFF, 1, 31'h7FFF_FFFE);
    send_item(K_CMP, 1, 2, 2, 4);
    send_item(K_CMP, -1, 3, 1, 3);
    send_item(K_CMP, 1, -3, 1, 3);
    send_item(K_CMP, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_item(K_NOP, '1, '1, '1, '1);
    send_item(K_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);

    // fill the block while the receiver holds off
    hold_off = 1;
    repeat (12) send_item(kind_t'($urandom_range(0, 6)), rand_value(), rand_den(),
                          rand_value(), rand_den());

    while (sent < 1900) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        k = kind_t'($urandom_range(0, 15) == 0 ? 7 : $urandom_range(0, 6));
        ad = ($urandom_range(0, 9) == 0) ? rand_value() : {1'b0, rand_den()};
        send_item(k, rand_value(), ad, rand_value(), rand_den());
      end
      if ($urandom_range(0, 2) == 0) pause_sender();
    end
    s_axis_tvalid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    $display("Sent %0d operand pairs, checked %0d results;", sent, sb.checked,
             " per kind add..nop: %0d %0d %0d %0d %0d %0d %0d %0d",
             kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3],
             kind_hits[4], kind_hits[5], kind_hits[6], kind_hits[7]);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
